>>> design/sfrs_pkg.sv
// Shared types, constants and helper functions for the servo frame receiver.
// No dependencies; every other design file refers to this package by scoped names.
package sfrs_pkg;

    localparam int CHANNELS      = 6;
    localparam int CH_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FRAME_LEN     = 3 + 2 * CHANNELS + 1;
    localparam int IDX_W         = $clog2(FRAME_LEN);
    localparam int RANGE_REGS    = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int QDEPTH        = 2;
    localparam int Q_AW          = $clog2(QDEPTH);

    localparam logic [7:0]  HDR0       = 8'hAA;
    localparam logic [7:0]  HDR1       = 8'h55;
    localparam logic [11:0] SAMPLE_MAX = 12'd4095;
    localparam logic [15:0] DEF_MIN    = 16'd1000;
    localparam logic [15:0] DEF_MAX    = 16'd2000;
    localparam logic [15:0] DEF_STEP   = 16'd50;

    localparam logic [CFG_IDX_W-1:0] REG_SLEW = CFG_IDX_W'(RANGE_REGS);

    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    localparam logic RES_STATUS = 1'b0;
    localparam logic RES_PULSE  = 1'b1;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic        frame_ok;
        logic [2:0]  channel;
        logic [15:0] pulse_us;
        logic        last;
    } rsp_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_FRAME = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic                        ok;
        logic [CHANNELS-1:0][11:0]   sample;
    } cmd_t;

    // x / 4095 for x below 2^28, by folding 4096 = 4095 + 1 twice
    function automatic logic [15:0] div4095(input logic [27:0] x);
        logic [16:0] y;
        logic [12:0] r;
        logic [16:0] q;
        y = {1'b0, x[27:12]} + {5'd0, x[11:0]};
        r = {8'd0, y[16:12]} + {1'b0, y[11:0]};
        q = {1'b0, x[27:12]} + {12'd0, y[16:12]} + {16'd0, (r >= {1'b0, SAMPLE_MAX})};
        return q[15:0];
    endfunction

endpackage

>>> design/servo_frame_receiver_slew_top.sv
// Top level of the servo frame receiver with slew limit: config registers and wiring.
// Depends on sfrs_pkg, sfrs_front, sfrs_queue and sfrs_back.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid/req_ready   | sfrs_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_ready   | sfrs_pkg::rsp_t
//   cfg     | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// Received bytes and timeouts are taken one per cycle while the command queue has room.
// A tick passes dispatch, then writes one pulse word per channel into the output register.
// A good frame passes dispatch and a status word, then the map unit's multiply and divide
// by 4095 states for each channel; a bad frame gets dispatch and the status word only.
// Reset is asynchronous; no clearing pass follows it. A stalled rsp holds the back end
// before each status or pulse word, and a full queue holds req.
module servo_frame_receiver_slew_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  sfrs_pkg::req_t                 req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output sfrs_pkg::rsp_t                 rsp_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sfrs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    logic [sfrs_pkg::CHANNELS-1:0][31:0] range_reg, range_next;
    logic [15:0]                         slew_reg, slew_next;
    logic                                cfg_we;
    logic                                push, q_full, q_pop, q_valid;
    sfrs_pkg::cmd_t                      push_cmd, q_cmd;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        range_next = range_reg;
        slew_next  = slew_reg;
        if (cfg_we)
        begin
            for (int i = 0; i < sfrs_pkg::CHANNELS; i++)
            begin
                if (i < sfrs_pkg::RANGE_REGS && cfg_index == sfrs_pkg::CFG_IDX_W'(i))
                    range_next[i] = cfg_data;
            end
            if (cfg_index == sfrs_pkg::REG_SLEW)
                slew_next = cfg_data[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfrs_pkg::CHANNELS; i++)
            begin
                range_reg[i] <= {sfrs_pkg::DEF_MIN, sfrs_pkg::DEF_MAX};
            end
            slew_reg <= sfrs_pkg::DEF_STEP;
        end
        else
        begin
            range_reg <= range_next;
            slew_reg  <= slew_next;
        end
    end

    sfrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    sfrs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    sfrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .ranges    (range_reg),
        .slew_step (slew_reg),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

>>> design/sfrs_front.sv
// Front end: collects received words into frames, checks header and XOR, queues commands.
// Depends on sfrs_pkg.
module sfrs_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  sfrs_pkg::req_t req_data,
    input  logic          q_full,
    output logic          push,
    output sfrs_pkg::cmd_t push_cmd
);

    logic [sfrs_pkg::IDX_W-1:0]           byte_index_reg, byte_index_next;
    logic [7:0]                           xor_reg, xor_next;
    logic                                 hdr_bad_reg, hdr_bad_next;
    logic [sfrs_pkg::CHANNELS-1:0][15:0]  pend_reg, pend_next;
    logic                                 acc;
    logic [sfrs_pkg::IDX_W-1:0]           k;
    logic [7:0]                           b;

    assign req_ready = !q_full;
    assign acc       = req_valid && req_ready;
    assign b         = req_data.data_byte;
    assign k         = byte_index_reg - sfrs_pkg::IDX_W'(3);

    always_comb
    begin
        byte_index_next = byte_index_reg;
        xor_next        = xor_reg;
        hdr_bad_next    = hdr_bad_reg;
        pend_next       = pend_reg;
        push            = 1'b0;
        push_cmd.kind   = sfrs_pkg::CMD_TICK;
        push_cmd.ok     = 1'b0;
        for (int i = 0; i < sfrs_pkg::CHANNELS; i++)
        begin
            push_cmd.sample[i] = (pend_reg[i] > {4'd0, sfrs_pkg::SAMPLE_MAX}) ?
                                 sfrs_pkg::SAMPLE_MAX : pend_reg[i][11:0];
        end
        if (acc)
        begin
            case (req_data.req_type)
                sfrs_pkg::REQ_TIMEOUT:
                begin
                    byte_index_next = '0;
                    xor_next        = '0;
                    hdr_bad_next    = 1'b0;
                end
                sfrs_pkg::REQ_TICK:
                begin
                    push = 1'b1;
                end
                sfrs_pkg::REQ_BYTE:
                begin
                    if (byte_index_reg == sfrs_pkg::IDX_W'(sfrs_pkg::FRAME_LEN - 1))
                    begin
                        push            = 1'b1;
                        push_cmd.kind   = sfrs_pkg::CMD_FRAME;
                        push_cmd.ok     = !hdr_bad_reg && (xor_reg == b);
                        byte_index_next = '0;
                        xor_next        = '0;
                        hdr_bad_next    = 1'b0;
                    end
                    else
                    begin
                        if (byte_index_reg == sfrs_pkg::IDX_W'(0) && b != sfrs_pkg::HDR0)
                            hdr_bad_next = 1'b1;
                        if (byte_index_reg == sfrs_pkg::IDX_W'(1) && b != sfrs_pkg::HDR1)
                            hdr_bad_next = 1'b1;
                        if (byte_index_reg == sfrs_pkg::IDX_W'(2) &&
                            b != 8'(sfrs_pkg::CHANNELS))
                            hdr_bad_next = 1'b1;
                        if (byte_index_reg >= sfrs_pkg::IDX_W'(3))
                        begin
                            for (int i = 0; i < sfrs_pkg::CHANNELS; i++)
                            begin
                                if (k[sfrs_pkg::IDX_W-1:1] == (sfrs_pkg::IDX_W-1)'(i))
                                begin
                                    if (!k[0])
                                        pend_next[i][15:8] = b;
                                    else
                                        pend_next[i][7:0] = b;
                                end
                            end
                        end
                        xor_next        = xor_reg ^ b;
                        byte_index_next = byte_index_reg + sfrs_pkg::IDX_W'(1);
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
            xor_reg        <= '0;
            hdr_bad_reg    <= 1'b0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            xor_reg        <= xor_next;
            hdr_bad_reg    <= hdr_bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

>>> design/sfrs_queue.sv
// Short command queue between front end and back end.
// Depends on sfrs_pkg.
module sfrs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfrs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output sfrs_pkg::cmd_t q_cmd
);

    sfrs_pkg::cmd_t                 entry_reg [sfrs_pkg::QDEPTH];
    logic [sfrs_pkg::Q_AW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [sfrs_pkg::Q_AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [sfrs_pkg::Q_AW:0]        count_reg, count_next;
    logic                           do_push, do_pop;

    assign full    = (count_reg == (sfrs_pkg::Q_AW + 1)'(sfrs_pkg::QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == sfrs_pkg::Q_AW'(sfrs_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + sfrs_pkg::Q_AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == sfrs_pkg::Q_AW'(sfrs_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + sfrs_pkg::Q_AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + (sfrs_pkg::Q_AW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (sfrs_pkg::Q_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> design/sfrs_back.sv
// Back end: runs frame and tick commands, maps samples into targets, slews pulses.
// Holds the output register. Depends on sfrs_pkg.
module sfrs_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  sfrs_pkg::cmd_t                        q_cmd,
    input  logic [sfrs_pkg::CHANNELS-1:0][31:0]   ranges,
    input  logic [15:0]                           slew_step,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output sfrs_pkg::rsp_t                        rsp_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_STATUS = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_TICK   = 5'b10000
    } state_t;

    state_t                                state_reg, state_next;
    logic [sfrs_pkg::CH_W-1:0]             cnt_reg, cnt_next;
    sfrs_pkg::cmd_t                        cmd_reg, cmd_next;
    logic [sfrs_pkg::CHANNELS-1:0][15:0]   tgt_reg, tgt_next;
    logic [sfrs_pkg::CHANNELS-1:0][15:0]   cur_reg, cur_next;
    logic                                  out_valid_reg, out_valid_next;
    sfrs_pkg::rsp_t                        out_reg, out_next;
    logic [27:0]                           prod_reg, prod_next;
    logic [15:0]                           lo_reg, lo_next;
    logic [15:0]                           hi_reg, hi_next;
    logic                                  rev_reg, rev_next;

    logic                                  out_free;
    logic                                  cnt_last;
    logic [15:0]                           mn, mx, span, q, p;
    logic [15:0]                           cur, tgt, d, cur_new;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign cnt_last  = (cnt_reg == sfrs_pkg::CH_W'(sfrs_pkg::CHANNELS - 1));
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    assign mn   = ranges[cnt_reg][31:16];
    assign mx   = ranges[cnt_reg][15:0];
    assign span = (mx < mn) ? (mn - mx) : (mx - mn);
    assign q    = sfrs_pkg::div4095(prod_reg);
    assign p    = rev_reg ? (hi_reg - q) : (lo_reg + q);

    assign cur  = cur_reg[cnt_reg];
    assign tgt  = tgt_reg[cnt_reg];

    always_comb
    begin
        cur_new = cur;
        d       = '0;
        if (cur < tgt)
        begin
            d       = ((tgt - cur) > slew_step) ? slew_step : (tgt - cur);
            cur_new = cur + d;
        end
        else if (cur > tgt)
        begin
            d       = ((cur - tgt) > slew_step) ? slew_step : (cur - tgt);
            cur_new = cur - d;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        rev_next       = rev_reg;
        q_pop          = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    cnt_next = '0;
                    state_next = (q_cmd.kind == sfrs_pkg::CMD_TICK) ? S_TICK : S_STATUS;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_next.result_kind = sfrs_pkg::RES_STATUS;
                    out_next.frame_ok    = cmd_reg.ok;
                    out_next.channel     = '0;
                    out_next.pulse_us    = '0;
                    out_next.last        = 1'b1;
                    state_next = cmd_reg.ok ? S_MUL : S_IDLE;
                end
            end
            S_MUL:
            begin
                rev_next   = (mx < mn);
                lo_next    = (mx < mn) ? mx : mn;
                hi_next    = (mx < mn) ? mn : mx;
                prod_next  = 28'(cmd_reg.sample[cnt_reg]) * 28'(span);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                tgt_next[cnt_reg] = p;
                if (cnt_last)
                    state_next = S_IDLE;
                else
                begin
                    cnt_next   = cnt_reg + sfrs_pkg::CH_W'(1);
                    state_next = S_MUL;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    cur_next[cnt_reg]    = cur_new;
                    out_valid_next       = 1'b1;
                    out_next.result_kind = sfrs_pkg::RES_PULSE;
                    out_next.frame_ok    = 1'b0;
                    out_next.channel     = 3'(cnt_reg);
                    out_next.pulse_us    = cur_new;
                    out_next.last        = cnt_last;
                    if (cnt_last)
                        state_next = S_IDLE;
                    else
                        cnt_next = cnt_reg + sfrs_pkg::CH_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < sfrs_pkg::CHANNELS; i++)
            begin
                tgt_reg[i] <= sfrs_pkg::DEF_MIN;
                cur_reg[i] <= sfrs_pkg::DEF_MIN;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            tgt_reg       <= tgt_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        out_reg  <= out_next;
        prod_reg <= prod_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        rev_reg  <= rev_next;
    end

endmodule

>>> design/sfrs_checker.sv
// Port-level checks on the result stream of the servo frame receiver, bound to the top.
// Depends on sfrs_pkg and servo_frame_receiver_slew_top.
module sfrs_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  sfrs_pkg::rsp_t rsp_data
);

    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_kind == sfrs_pkg::RES_STATUS |->
        rsp_data.last && rsp_data.channel == 3'd0 && rsp_data.pulse_us == 16'd0)
        else $error("status word malformed");

    a_pulse_channel: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_kind == sfrs_pkg::RES_PULSE |->
        rsp_data.channel < 3'(sfrs_pkg::CHANNELS) && !rsp_data.frame_ok)
        else $error("pulse word malformed");

    a_pulse_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_kind == sfrs_pkg::RES_PULSE |->
        rsp_data.last == (rsp_data.channel == 3'(sfrs_pkg::CHANNELS - 1)))
        else $error("last flag on wrong channel");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled word changed");

endmodule

bind servo_frame_receiver_slew_top sfrs_checker u_sfrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data)
);
